// File: rtl/core/rtf_pkg.sv
// shared types and constants for the printer escape to rtf filter
// depends on nothing; imported by rtf_decode, rtf_serializer and the top level
package rtf_pkg;

  localparam int unsigned TEXT_MAX = 6;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned IDX_W    = 3;

  // control bytes of the printer stream
  localparam logic [7:0] BYTE_ESC    = 8'h1B;
  localparam logic [7:0] BYTE_FF     = 8'h0C;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_BSLASH = 8'h5C;
  localparam logic [7:0] BYTE_LBRACE = 8'h7B;
  localparam logic [7:0] BYTE_RBRACE = 8'h7D;

  // escape commands
  localparam logic [7:0] CMD_BOLD_ON   = 8'h45;  // 'E'
  localparam logic [7:0] CMD_BOLD_OFF  = 8'h46;  // 'F'
  localparam logic [7:0] CMD_ITAL_ON   = 8'h34;  // '4'
  localparam logic [7:0] CMD_ITAL_OFF  = 8'h35;  // '5'
  localparam logic [7:0] CMD_UNDERLINE = 8'h2D;  // '-'

  // text element 0 goes out first
  typedef logic [TEXT_MAX-1:0][7:0] text_bytes_t;

  typedef struct packed {
    text_bytes_t            chars;
    logic [CNT_W-1:0]       count;
  } text_t;

  typedef struct packed {
    logic escape_pending;
    logic underline_active;
  } flt_state_t;

  typedef struct packed {
    logic busy;
    logic at_last;
  } ser_status_t;

endpackage

// File: rtl/core/rtf_decode.sv
// combinational translation of one printer byte into up to six text bytes
// depends on rtf_pkg
module rtf_decode import rtf_pkg::*; (
  input  logic       raw_mode,
  input  logic [7:0] data_byte,
  input  flt_state_t state,
  output text_t      text,
  output flt_state_t state_next
);

  always_comb begin
    text.chars = '0;
    text.count = '0;
    state_next = state;
    if (raw_mode) begin
      text.chars[0] = data_byte;
      text.count    = CNT_W'(1);
    end else if (state.escape_pending) begin
      state_next.escape_pending = 1'b0;
      unique case (data_byte)
        CMD_BOLD_ON: begin
          text.chars[0] = BYTE_BSLASH; text.chars[1] = 8'h62; text.chars[2] = 8'h20;
          text.count = CNT_W'(3);
        end
        CMD_BOLD_OFF: begin
          text.chars[0] = BYTE_BSLASH; text.chars[1] = 8'h62; text.chars[2] = 8'h30;
          text.chars[3] = 8'h20;
          text.count = CNT_W'(4);
        end
        CMD_ITAL_ON: begin
          text.chars[0] = BYTE_BSLASH; text.chars[1] = 8'h69; text.chars[2] = 8'h20;
          text.count = CNT_W'(3);
        end
        CMD_ITAL_OFF: begin
          text.chars[0] = BYTE_BSLASH; text.chars[1] = 8'h69; text.chars[2] = 8'h30;
          text.chars[3] = 8'h20;
          text.count = CNT_W'(4);
        end
        CMD_UNDERLINE: begin
          text.chars[0] = BYTE_BSLASH; text.chars[1] = 8'h75; text.chars[2] = 8'h6C;
          if (state.underline_active) begin
            text.chars[3] = 8'h30; text.chars[4] = 8'h20;
            text.count = CNT_W'(5);
          end else begin
            text.chars[3] = 8'h20;
            text.count = CNT_W'(4);
          end
          state_next.underline_active = ~state.underline_active;
        end
        default: begin
          // unknown command: consumed silently
          text.count = '0;
        end
      endcase
    end else begin
      unique case (data_byte)
        BYTE_FF: begin
          text.chars[0] = BYTE_BSLASH; text.chars[1] = 8'h70; text.chars[2] = 8'h61;
          text.chars[3] = 8'h67; text.chars[4] = 8'h65; text.chars[5] = 8'h20;
          text.count = CNT_W'(6);
        end
        BYTE_CR: begin
          text.chars[0] = BYTE_BSLASH; text.chars[1] = 8'h6C; text.chars[2] = 8'h69;
          text.chars[3] = 8'h6E; text.chars[4] = 8'h65; text.chars[5] = 8'h20;
          text.count = CNT_W'(6);
        end
        BYTE_BSLASH, BYTE_LBRACE, BYTE_RBRACE: begin
          text.chars[0] = BYTE_BSLASH; text.chars[1] = data_byte;
          text.count = CNT_W'(2);
        end
        BYTE_ESC: begin
          state_next.escape_pending = 1'b1;
        end
        default: begin
          text.chars[0] = data_byte;
          text.count    = CNT_W'(1);
        end
      endcase
    end
  end

endmodule

// File: rtl/core/rtf_serializer.sv
// holds one translated text and sends it out a byte per transfer
// depends on rtf_pkg
module rtf_serializer import rtf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  text_t       text,
  output ser_status_t status,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  output logic        m_tlast
);

  logic             valid;
  text_bytes_t      chars;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] idx;
  logic             at_last;

  assign at_last = (CNT_W'(idx) + CNT_W'(1)) == count;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (valid && m_tready) begin
      if (at_last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars <= text.chars;
      count <= text.count;
    end
  end

  assign status.busy    = valid;
  assign status.at_last = at_last;

  assign m_tvalid = valid;
  assign m_tdata  = chars[idx];
  assign m_tlast  = valid && at_last;

endmodule

// File: rtl/core/printer_escape_to_rtf_filter.sv
// top level of the printer escape to rtf filter
// depends on rtf_pkg, rtf_decode and rtf_serializer
//
// usage:
//   slave channel (s_tvalid/s_tready/s_tdata) takes one printer byte per transfer
//   master channel (m_tvalid/m_tready/m_tdata/m_tlast) gives the text bytes;
//   m_tlast marks the final byte caused by one printer byte
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes raw_mode; always ready,
//   write it only while the filter is idle
// datapath: a byte taken sits in the input register, is translated and, once the
//   output buffer is free, is loaded into it; the buffer's registers drive m_tdata
// throughput: a printer byte that yields n text bytes (1 to 6) holds the output
//   for n transfers; bytes that yield one text byte flow at one per cycle while
//   m_tready stays high, and silent bytes (escape, unknown command) pass the
//   input register without touching the output; the one-byte-wide output sets the pace
// reset: rst (synchronous) empties both registers, clears raw_mode, the
//   escape flag and the underline toggle
// stall: with m_tready low the output buffer holds its byte; the input register
//   still takes bytes until it holds one that yields text, then s_tready drops
module printer_escape_to_rtf_filter import rtf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // input bytes
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  // text bytes
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,
  // raw_mode register write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  logic        raw_mode;
  logic        in_valid;
  logic [7:0]  in_byte;
  flt_state_t  state;
  flt_state_t  state_next;
  text_t       text;
  ser_status_t ser_status;
  logic        ser_free;
  logic        in_advance;
  logic        ser_load;

  // config register, taken any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      raw_mode <= cfg_data;
    end
  end

  // input register
  assign s_tready = !in_valid || in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // translation of the held byte against the current escape/underline state
  rtf_decode u_decode (
    .raw_mode   (raw_mode),
    .data_byte  (in_byte),
    .state      (state),
    .text       (text),
    .state_next (state_next)
  );

  // output buffer can take new text when empty or when its last byte leaves now
  assign ser_free   = !ser_status.busy || (m_tready && ser_status.at_last);
  // silent bytes never wait on the output
  assign in_advance = in_valid && ((text.count == '0) || ser_free);
  assign ser_load   = in_advance && (text.count != '0);

  // escape flag and underline toggle move with each translated byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_advance) begin
      state <= state_next;
    end
  end

  rtf_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .load     (ser_load),
    .text     (text),
    .status   (ser_status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // checks
  // reset leaves no text pending
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // input stalls only with a byte held
  assert property (@(posedge clk) disable iff (rst) !s_tready |-> in_valid)
    else $error("input stalled while input register empty");

  // a loaded text must come out starting at its first byte
  assert property (@(posedge clk) disable iff (rst)
      ser_load |=> m_tvalid && (m_tdata == $past(text.chars[0]))
                   && (m_tlast == ($past(text.count) == CNT_W'(1))))
    else $error("loaded text not presented");

  // raw bytes leave the escape and underline state alone
  assert property (@(posedge clk) disable iff (rst)
      (in_advance && raw_mode) |=> $stable(state))
    else $error("state changed by a raw byte");

endmodule

// File: bench/tb_top.sv
// self-checking bench for printer_escape_to_rtf_filter: directed table, then random phases
// depends on rtf_pkg and the filter rtl; predicts text bytes from its own model of the filter
`timescale 1ns / 100ps

module tb_top import rtf_pkg::*; ();

  localparam int CLK_HALF      = 10;
  localparam int SETTLE_CYCLES = 6;       // margin after the expected bytes are out
  localparam int CYCLE_LIMIT   = 400000;
  localparam int NUM_DIRECTED  = 28;
  localparam int PHASE_TEXT    = 75;      // text-producing bytes per random phase

  // one expected output transfer
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } rtf_char_t;

  // directed row: either a raw_mode write or one printer byte
  typedef struct {
    bit         cfg_write;
    logic [7:0] value;
    bit         typed;      // expected text given in the row
    string      text;
  } stim_row_t;

  localparam logic [7:0] ESC_CMDS [5] = '{CMD_BOLD_ON, CMD_BOLD_OFF, CMD_ITAL_ON,
                                         CMD_ITAL_OFF, CMD_UNDERLINE};
  localparam logic [7:0] RTF_SPECIALS [5] = '{BYTE_FF, BYTE_CR, BYTE_BSLASH,
                                             BYTE_LBRACE, BYTE_RBRACE};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] data_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  // predictor state
  bit text_raw;
  bit esc_armed;
  bit ul_on;

  rtf_char_t  rtf_expected [$];
  int         error_count = 0;
  int         cycle_count = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{1'b0, 8'h00,         1'b0, ""},
    '{1'b0, 8'hFF,         1'b0, ""},
    '{1'b0, BYTE_FF,       1'b1, "\\page "},
    '{1'b0, BYTE_CR,       1'b1, "\\line "},
    '{1'b0, BYTE_BSLASH,   1'b1, "\\\\"},
    '{1'b0, BYTE_LBRACE,   1'b1, "\\{"},
    '{1'b0, BYTE_RBRACE,   1'b1, "\\}"},
    '{1'b0, BYTE_ESC,      1'b1, ""},
    '{1'b0, CMD_BOLD_ON,   1'b1, "\\b "},
    '{1'b0, BYTE_ESC,      1'b1, ""},
    '{1'b0, CMD_BOLD_OFF,  1'b1, "\\b0 "},
    '{1'b0, BYTE_ESC,      1'b1, ""},
    '{1'b0, CMD_ITAL_ON,   1'b1, "\\i "},
    '{1'b0, BYTE_ESC,      1'b1, ""},
    '{1'b0, CMD_ITAL_OFF,  1'b1, "\\i0 "},
    '{1'b0, BYTE_ESC,      1'b1, ""},
    '{1'b0, CMD_UNDERLINE, 1'b1, "\\ul "},
    // escape after escape: the second one is consumed, nothing stays armed
    '{1'b0, BYTE_ESC,      1'b1, ""},
    '{1'b0, BYTE_ESC,      1'b1, ""},
    '{1'b0, 8'h41,         1'b1, "A"},
    // pending escape must survive a trip through raw mode
    '{1'b0, BYTE_ESC,      1'b1, ""},
    '{1'b1, 8'h01,         1'b0, ""},
    '{1'b0, BYTE_ESC,      1'b0, ""},
    '{1'b0, CMD_UNDERLINE, 1'b1, "-"},
    '{1'b1, 8'h00,         1'b0, ""},
    '{1'b0, CMD_UNDERLINE, 1'b1, "\\ul0 "},
    // unknown command after escape is swallowed
    '{1'b0, BYTE_ESC,      1'b1, ""},
    '{1'b0, 8'h5A,         1'b1, ""}
  };

  always #(CLK_HALF) clk = ~clk;

  printer_escape_to_rtf_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // returns 1 when the byte goes out unchanged, else fills txt (maybe empty)
  function automatic bit translate_byte(input logic [7:0] b, output string txt);
    txt = "";
    if (text_raw) return 1'b1;
    if (esc_armed) begin
      esc_armed = 1'b0;
      case (b)
        CMD_BOLD_ON:   txt = "\\b ";
        CMD_BOLD_OFF:  txt = "\\b0 ";
        CMD_ITAL_ON:   txt = "\\i ";
        CMD_ITAL_OFF:  txt = "\\i0 ";
        CMD_UNDERLINE: begin
          txt = ul_on ? "\\ul0 " : "\\ul ";
          ul_on = !ul_on;
        end
        default: ;
      endcase
      return 1'b0;
    end
    case (b)
      BYTE_FF:     txt = "\\page ";
      BYTE_CR:     txt = "\\line ";
      BYTE_BSLASH: txt = "\\\\";
      BYTE_LBRACE: txt = "\\{";
      BYTE_RBRACE: txt = "\\}";
      BYTE_ESC:    esc_armed = 1'b1;
      default:     return 1'b1;
    endcase
    return 1'b0;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      rtf_expected.push_back('{ch: s[i], last: (i == s.len() - 1)});
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // hold the sender until every expected byte is out and the pipe is drained
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (rtf_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_raw(input bit v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    text_raw = v;
  endtask

  // one printer byte transfer; n_out is the number of text bytes it causes
  task automatic send_byte(input logic [7:0] b, input bit typed, input string text,
                           output int n_out);
    string txt;
    bit    passes;
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // predictor runs on every transfer so its state tracks the filter
    passes = translate_byte(b, txt);
    if (typed) begin
      push_text(text);
      n_out = text.len();
    end else if (passes) begin
      rtf_expected.push_back('{ch: b, last: 1'b1});
      n_out = 1;
    end else begin
      push_text(txt);
      n_out = txt.len();
    end
  endtask

  // receiver stalls at the phase's rate
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // output checker: each text transfer against the oldest expectation
  always @(posedge clk) begin
    rtf_char_t exp_char;
    if (!rst && m_tvalid && m_tready) begin
      if (rtf_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
      end else begin
        exp_char = rtf_expected.pop_front();
        if (m_tdata !== exp_char.ch)
          report_mismatch($sformatf("out_byte %02h, expected %02h", m_tdata, exp_char.ch));
        if (m_tlast !== exp_char.last)
          report_mismatch($sformatf("last %0b, expected %0b", m_tlast, exp_char.last));
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("printer_escape_to_rtf_filter test failed");
      $finish;
    end
  end

  initial begin
    int n_out;
    int text_items;
    int roll;
    logic [7:0] cmd;

    text_raw  = 1'b0;
    esc_armed = 1'b0;
    ul_on     = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, with no idling on either side
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_write)
        write_raw(directed_rows[i].value[0]);
      else
        send_byte(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].text,
                  n_out);
    end

    // random phases: none, sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      write_raw(phase == 1);
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      text_items = 0;
      while (text_items < PHASE_TEXT) begin
        // halfway: drain completely, then set the mode at random
        if (text_items == PHASE_TEXT / 2) begin
          write_raw(1'($urandom_range(1)));
          text_items++;
        end
        roll = $urandom_range(99);
        if (roll < 40) begin
          // escape sequence, mostly a known command, sometimes garbage
          send_byte(BYTE_ESC, 1'b0, "", n_out);
          text_items += (n_out != 0);
          if ($urandom_range(9) == 0)
            cmd = 8'($urandom_range(255));
          else
            cmd = ESC_CMDS[$urandom_range(4)];
          send_byte(cmd, 1'b0, "", n_out);
        end else if (roll < 65) begin
          send_byte(RTF_SPECIALS[$urandom_range(4)], 1'b0, "", n_out);
        end else begin
          send_byte(8'($urandom_range(255)), 1'b0, "", n_out);
        end
        text_items += (n_out != 0);
      end
    end

    // back to rtf mode at the end so the last write is the reset value
    write_raw(1'b0);
    idle_pct  = 0;
    stall_pct = 0;
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("printer_escape_to_rtf_filter test passed");
    end else begin
      $display("printer_escape_to_rtf_filter test failed");
    end
    $finish;
  end

endmodule
